[rtl/core/fqp_pkg.sv]
package fqp_pkg;

   localparam int unsigned ID_MAX_DEF   = 256;
   localparam int unsigned READ_MAX_DEF = 1024;

   localparam logic [7:0] CH_AT   = 8'h40;
   localparam logic [7:0] CH_PLUS = 8'h2B;
   localparam logic [7:0] CH_NL   = 8'h0A;
   localparam logic [7:0] CH_SP   = 8'h20;
   localparam logic [7:0] CH_TAB  = 8'h09;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LO_A = 8'h61;
   localparam logic [7:0] CH_LO_Z = 8'h7A;
   localparam logic [7:0] CASE_MASK = 8'hDF;

   typedef enum logic [2:0] {
      PH_START,
      PH_ID,
      PH_HDRSKIP,
      PH_SEQ,
      PH_PLUS,
      PH_PLUSLINE,
      PH_QUAL
   } phase_type;

   typedef enum logic [1:0] {
      KIND_ID   = 2'd0,
      KIND_SEQ  = 2'd1,
      KIND_QUAL = 2'd2,
      KIND_REC  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_EOF_START  = 3'd1,
      ST_BAD_START  = 3'd2,
      ST_EOF_ID     = 3'd3,
      ST_NO_PLUS    = 3'd4,
      ST_EOF_QUAL   = 3'd5
   } status_type;

   // classified input byte, front to back
   typedef struct packed {
      logic [7:0] data;
      logic       eof;
      logic       ws;
      logic       nl;
      logic       at;
      logic       plus;
      logic       lower;
   } byte_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  char_value;
      logic [9:0]  position;
      status_type  status;
      logic [10:0] read_length;
   } rsp_type;

   function automatic byte_type classify(input logic [7:0] c, input logic eof);
      byte_type b;
      b.data  = c;
      b.eof   = eof;
      b.ws    = (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
      b.nl    = (c == CH_NL);
      b.at    = (c == CH_AT);
      b.plus  = (c == CH_PLUS);
      b.lower = (c >= CH_LO_A) && (c <= CH_LO_Z);
      return b;
   endfunction

endpackage

[rtl/core/fastq_record_parser.sv]
// FASTQ record parser.
// Input queue: one text byte per transfer on req_data_byte, or an end of
// file with req_at_end high (byte ignored). A transfer happens when req_push
// is high and req_full is low.
// Result queue: while rsp_empty is low the oldest result sits on the rsp_
// ports; rsp_pop takes it. Each byte gives zero or one result: a kept
// identifier, sequence or quality character with its position, or a record
// item with status and read length, after which the parser expects '@' again.
// A byte waits in the input queue; its result is then written to the result
// queue. The back takes one byte per cycle while the result queue has room;
// the front classifies bytes into a two-entry queue, the back runs the parse
// state machine and writes a two-entry result queue.
// Reset (synchronous) empties both queues and returns to record start.
// When the receiver stalls, the result queue fills, the back stops taking
// bytes, and req_full rises once the input queue holds two bytes.
module fastq_record_parser #(
   parameter int unsigned ID_MAX   = fqp_pkg::ID_MAX_DEF,
   parameter int unsigned READ_MAX = fqp_pkg::READ_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_at_end,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_item_kind,
   output logic [7:0]  rsp_char_value,
   output logic [9:0]  rsp_position,
   output logic [2:0]  rsp_record_status,
   output logic [10:0] rsp_read_length
);

   logic              q_valid;
   logic              q_pop;
   fqp_pkg::byte_type q_item;
   fqp_pkg::rsp_type  rsp_item;

   fqp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data_byte (req_data_byte),
      .req_at_end    (req_at_end),
      .req_full      (req_full),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   fqp_back #(
      .ID_MAX   (ID_MAX),
      .READ_MAX (READ_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   assign rsp_item_kind     = rsp_item.kind;
   assign rsp_char_value    = rsp_item.char_value;
   assign rsp_position      = rsp_item.position;
   assign rsp_record_status = rsp_item.status;
   assign rsp_read_length   = rsp_item.read_length;

   a_reset_empty: assert property (@(posedge clock) reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   a_rec_fields: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item_kind == fqp_pkg::KIND_REC) |->
         (rsp_char_value == 8'd0 && rsp_position == 10'd0 &&
          rsp_record_status <= fqp_pkg::ST_EOF_QUAL))
      else $error("malformed record item");

   a_char_fields: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item_kind != fqp_pkg::KIND_REC) |->
         (rsp_record_status == fqp_pkg::ST_OK && rsp_read_length == 11'd0))
      else $error("character item carries record fields");

   a_seq_upper: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item_kind == fqp_pkg::KIND_SEQ) |->
         !(rsp_char_value >= fqp_pkg::CH_LO_A && rsp_char_value <= fqp_pkg::CH_LO_Z))
      else $error("lower-case base emitted");

endmodule

[rtl/core/fqp_front.sv]
module fqp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic [7:0]       req_data_byte,
   input  logic             req_at_end,
   output logic             req_full,
   output logic             q_valid,
   output fqp_pkg::byte_type q_item,
   input  logic             q_pop
);

   fqp_pkg::byte_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push_ok;
   logic       pop_ok;

   assign req_full = (count_ff == 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = mem_ff[rd_ptr_ff];
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= fqp_pkg::classify(req_data_byte, req_at_end);
      end
   end

endmodule

[rtl/core/fqp_back.sv]
module fqp_back #(
   parameter int unsigned ID_MAX   = fqp_pkg::ID_MAX_DEF,
   parameter int unsigned READ_MAX = fqp_pkg::READ_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  fqp_pkg::byte_type q_item,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output fqp_pkg::rsp_type  rsp_item
);

   localparam int unsigned FMAX = (ID_MAX > READ_MAX) ? ID_MAX : READ_MAX;
   localparam int unsigned CW   = $clog2(FMAX + 1);
   localparam int unsigned KW   = $clog2(READ_MAX + 1);

   fqp_pkg::phase_type phase_ff, phase_in;
   logic [CW-1:0] fc_ff, fc_in;
   logic [KW-1:0] kb_ff, kb_in;

   logic             step;
   logic             res_valid;
   fqp_pkg::rsp_type res;
   logic [CW+9:0]    fc_ext;
   logic [KW+10:0]   kb_ext;

   fqp_pkg::rsp_type mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       pop_ok;

   assign step   = q_valid && (count_ff != 2'd2);
   assign q_pop  = step;
   assign fc_ext = {10'd0, fc_ff};
   assign kb_ext = {11'd0, kb_ff};

   always_comb begin
      phase_in        = phase_ff;
      fc_in           = fc_ff;
      kb_in           = kb_ff;
      res_valid       = 1'b0;
      res.kind        = fqp_pkg::KIND_REC;
      res.char_value  = 8'd0;
      res.position    = 10'd0;
      res.status      = fqp_pkg::ST_OK;
      res.read_length = 11'd0;

      case (phase_ff)
         fqp_pkg::PH_ID: begin
            if (q_item.eof) begin
               res_valid = 1'b1;
               res.status = (fc_ff < CW'(ID_MAX)) ? fqp_pkg::ST_EOF_ID : fqp_pkg::ST_NO_PLUS;
            end else if (q_item.ws) begin
               phase_in = q_item.nl ? fqp_pkg::PH_SEQ : fqp_pkg::PH_HDRSKIP;
               fc_in    = '0;
            end else if (fc_ff >= CW'(ID_MAX)) begin
               phase_in = fqp_pkg::PH_HDRSKIP;
               fc_in    = '0;
            end else begin
               res_valid      = 1'b1;
               res.kind       = fqp_pkg::KIND_ID;
               res.char_value = q_item.data;
               res.position   = fc_ext[9:0];
               fc_in          = fc_ff + CW'(1);
            end
         end
         fqp_pkg::PH_HDRSKIP: begin
            if (q_item.eof) begin
               res_valid  = 1'b1;
               res.status = fqp_pkg::ST_NO_PLUS;
            end else if (q_item.nl) begin
               phase_in = fqp_pkg::PH_SEQ;
               fc_in    = '0;
            end
         end
         fqp_pkg::PH_SEQ: begin
            if (q_item.eof) begin
               res_valid  = 1'b1;
               res.status = fqp_pkg::ST_NO_PLUS;
            end else if (q_item.nl) begin
               phase_in = fqp_pkg::PH_PLUS;
            end else if (kb_ff < KW'(READ_MAX) && !q_item.ws) begin
               res_valid      = 1'b1;
               res.kind       = fqp_pkg::KIND_SEQ;
               res.char_value = q_item.lower ? (q_item.data & fqp_pkg::CASE_MASK)
                                             : q_item.data;
               res.position   = kb_ext[9:0];
               kb_in          = kb_ff + KW'(1);
            end
         end
         fqp_pkg::PH_PLUS: begin
            if (q_item.eof || !q_item.plus) begin
               res_valid  = 1'b1;
               res.status = fqp_pkg::ST_NO_PLUS;
            end else begin
               phase_in = fqp_pkg::PH_PLUSLINE;
            end
         end
         fqp_pkg::PH_PLUSLINE: begin
            if (q_item.eof) begin
               res_valid  = 1'b1;
               res.status = fqp_pkg::ST_EOF_QUAL;
            end else if (q_item.nl) begin
               phase_in = fqp_pkg::PH_QUAL;
               fc_in    = '0;
            end
         end
         fqp_pkg::PH_QUAL: begin
            if (q_item.eof) begin
               res_valid  = 1'b1;
               res.status = fqp_pkg::ST_EOF_QUAL;
            end else if (q_item.nl) begin
               res_valid  = 1'b1;
               res.status = fqp_pkg::ST_OK;
            end else if (fc_ff < CW'(READ_MAX) && !q_item.ws) begin
               res_valid      = 1'b1;
               res.kind       = fqp_pkg::KIND_QUAL;
               res.char_value = q_item.data;
               res.position   = fc_ext[9:0];
               fc_in          = fc_ff + CW'(1);
            end
         end
         default: begin
            if (q_item.eof) begin
               res_valid  = 1'b1;
               res.status = fqp_pkg::ST_EOF_START;
            end else if (!q_item.at) begin
               res_valid  = 1'b1;
               res.status = fqp_pkg::ST_BAD_START;
            end else begin
               phase_in = fqp_pkg::PH_ID;
               fc_in    = '0;
               kb_in    = '0;
            end
         end
      endcase

      // record item closes the record
      if (res_valid && res.kind == fqp_pkg::KIND_REC) begin
         res.read_length = kb_ext[10:0];
         phase_in        = fqp_pkg::PH_START;
         fc_in           = '0;
         kb_in           = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fqp_pkg::PH_START;
         fc_ff    <= '0;
         kb_ff    <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         fc_ff    <= fc_in;
         kb_ff    <= kb_in;
      end
   end

   // result queue
   assign rsp_empty = (count_ff == 2'd0);
   assign rsp_item  = mem_ff[rd_ptr_ff];
   assign pop_ok    = rsp_pop && !rsp_empty;

   always_comb begin
      count_in = count_ff + {1'b0, step && res_valid} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (step && res_valid) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop_ok) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         mem_ff[wr_ptr_ff] <= res;
      end
   end

endmodule
